// ----- hdl/bac_pkg.sv -----
// ----------------------------------------------------------------------------
// bac_pkg
// Shared constants and the elaboration-time log2 helper for the barometric
// altitude block.
// ----------------------------------------------------------------------------
package bac_pkg;

  localparam logic [23:0] REF_PRESSURE = 24'd4150272;  // 1013.25 mbar in Q12
  localparam logic [31:0] LOG10_2_Q30  = 32'd323228497;
  localparam logic [31:0] SCALE_HEIGHT = 32'd8400;
  localparam logic [31:0] RECIP_15     = 32'd69905;    // floor(2^20 / 15)
  localparam logic [31:0] RECIP_273    = 32'd15732480; // floor(2^32 / 273)
  localparam logic [31:0] DIV_273      = 32'd273;
  localparam logic [16:0] KELVIN_DEG   = 17'd80768;    // (273 + 42.5) in Q8
  localparam logic signed [17:0] ALT_MAX = 18'sd131071;
  localparam logic signed [17:0] ALT_MIN = -18'sd131072;

  localparam logic OP_MEASURE = 1'b0;
  localparam logic OP_CAPTURE = 1'b1;

  // log2 of x in Q16 with truncated fraction bits; evaluated at elaboration.
  function automatic logic [31:0] log2_q16(input logic [31:0] x);
    logic [31:0] n;
    logic [31:0] r;
    logic [63:0] m;
    n = 32'd0;
    for (int k = 0; k < 31; k++) begin
      if ((x >> (k + 1)) != 32'd0) begin
        n = 32'(k + 1);
      end
    end
    m = 64'(x) << (32'd30 - n);
    r = n << 16;
    for (int i = 15; i >= 0; i--) begin
      m = (m * m) >> 30;
      if (m >= 64'h8000_0000) begin
        m = m >> 1;
        r = r | (32'd1 << i);
      end
    end
    return r;
  endfunction

  localparam logic [31:0] LOG2_REF = log2_q16({8'd0, REF_PRESSURE});

endpackage

// ----- hdl/bac_if.sv -----
// ----------------------------------------------------------------------------
// bac_if
// Valid/ready channels for the sample input and the altitude result.
// ----------------------------------------------------------------------------
interface bac_in_if;
  logic               valid;
  logic               ready;
  logic               opcode;
  logic [7:0]         status_byte;
  logic [23:0]        pressure_raw;
  logic signed [15:0] temperature_raw;

  modport source(output valid, opcode, status_byte, pressure_raw, temperature_raw,
                 input ready);
  modport sink(input valid, opcode, status_byte, pressure_raw, temperature_raw,
               output ready);
endinterface

interface bac_out_if;
  logic               valid;
  logic               ready;
  logic signed [17:0] altitude_abs;
  logic signed [18:0] altitude_rel;

  modport source(output valid, altitude_abs, altitude_rel, input ready);
  modport sink(input valid, altitude_abs, altitude_rel, output ready);
endinterface

// ----- hdl/bac_mul.sv -----
// ----------------------------------------------------------------------------
// bac_mul
// Shared 32 x 32 unsigned multiplier used for every product in the block.
// ----------------------------------------------------------------------------
module bac_mul (
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [63:0] p
);
  assign p = {32'd0, a} * {32'd0, b};
endmodule

// ----- hdl/barometric_altitude_calc.sv -----
// ----------------------------------------------------------------------------
// barometric_altitude_calc
// A sequencer drives one shared 32 x 32 multiplier through the temperature
// factor, sixteen squaring steps of the log2 and the log difference, and the
// final scaling products, then loads the sample's result into the output
// register. The block takes no new sample until the current one is finished.
// A finished result waits in the output register, so the next sample may be
// taken while it is pending; a second finished result then holds its last
// step until the output register is free.
// ----------------------------------------------------------------------------
module barometric_altitude_calc (
  input  logic          clk,
  input  logic          rst,
  bac_in_if.sink        sample,
  bac_out_if.source     result
);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_TMUL  = 11'b000_0000_0010,
    S_TCORR = 11'b000_0000_0100,
    S_FMUL  = 11'b000_0000_1000,
    S_FCHK  = 11'b000_0001_0000,
    S_FFIN  = 11'b000_0010_0000,
    S_LOG   = 11'b000_0100_0000,
    S_DLOG  = 11'b000_1000_0000,
    S_DMUL  = 11'b001_0000_0000,
    S_LMUL  = 11'b010_0000_0000,
    S_DONE  = 11'b100_0000_0000
  } state_t;

  state_t             state;
  logic [23:0]        held_pressure;
  logic signed [15:0] held_temperature;
  logic signed [17:0] zero_reference;
  logic               opcode;
  logic [63:0]        prod;
  logic [24:0]        num;
  logic [16:0]        fq;
  logic [16:0]        factor;
  logic [3:0]         step;
  logic [15:0]        frac;
  logic [4:0]         lead;
  logic [22:0]        mag_d;
  logic               neg;
  logic               out_valid;
  logic signed [17:0] out_abs;
  logic signed [18:0] out_rel;

  logic [31:0] op_a;
  logic [31:0] op_b;
  logic [63:0] mul_p;

  bac_mul u_mul (.a(op_a), .b(op_b), .p(mul_p));

  function automatic logic [16:0] KELVIN_DEG_ADD(input logic [14:0] q);
    return bac_pkg::KELVIN_DEG + {2'd0, q};
  endfunction

  function automatic logic [16:0] KELVIN_DEG_SUB(input logic [14:0] q);
    return bac_pkg::KELVIN_DEG - {2'd0, q};
  endfunction

  // Temperature magnitude times 8 and its division by 15.
  logic [16:0] t_mag;
  logic [19:0] t_a;
  logic [14:0] q15;
  logic [19:0] r15;
  logic [14:0] q15_fix;
  logic [16:0] kel;

  always_comb begin
    t_mag   = held_temperature[15] ? 17'(-$signed({held_temperature[15], held_temperature}))
                                   : {1'b0, held_temperature};
    t_a     = {t_mag, 3'd0};
    q15     = prod[34:20];
    r15     = t_a - ({5'd0, q15} << 4) + {5'd0, q15};
    q15_fix = q15 + ((r15 >= 20'd15) ? 15'd1 : 15'd0);
    kel     = held_temperature[15] ? KELVIN_DEG_SUB(q15_fix) : KELVIN_DEG_ADD(q15_fix);
  end

  // Leading one of the held pressure and its Q30 mantissa.
  logic [30:0] m0;
  always_comb begin
    lead = 5'd0;
    for (int k = 1; k < 24; k++) begin
      if (held_pressure[k]) begin
        lead = 5'(k);
      end
    end
    m0 = {7'd0, held_pressure} << (5'd30 - lead);
  end

  // Renormalize the previous square back into [1, 2) in Q30.
  logic        sq_bit;
  logic [30:0] m_norm;
  assign sq_bit = prod[61];
  assign m_norm = sq_bit ? prod[61:31] : prod[60:30];

  // Log difference in Q16.
  logic [31:0]        log_p;
  logic signed [23:0] d;
  assign log_p = {11'd0, lead, frac | {15'd0, sq_bit}};
  assign d     = $signed(bac_pkg::LOG2_REF[23:0]) - $signed(log_p[23:0]);

  always_comb begin
    op_a = 32'd0;
    op_b = 32'd0;
    case (state)
      S_TMUL: begin
        op_a = {12'd0, t_a};
        op_b = bac_pkg::RECIP_15;
      end
      S_FMUL: begin
        op_a = {7'd0, num};
        op_b = bac_pkg::RECIP_273;
      end
      S_FCHK: begin
        op_a = {15'd0, prod[48:32]};
        op_b = bac_pkg::DIV_273;
      end
      S_LOG: begin
        op_a = (step == 4'd0) ? {1'b0, m0} : {1'b0, m_norm};
        op_b = op_a;
      end
      S_DMUL: begin
        op_a = {9'd0, mag_d};
        op_b = bac_pkg::LOG10_2_Q30;
      end
      S_LMUL: begin
        op_a = prod[61:30];
        op_b = bac_pkg::SCALE_HEIGHT;
      end
      S_DONE: begin
        op_a = prod[31:0];
        op_b = {15'd0, factor};
      end
      default: begin
        op_a = 32'd0;
        op_b = 32'd0;
      end
    endcase
  end

  // Final saturation; S_DONE first forms the last product, then reports.
  logic               last_phase;
  logic [31:0]        mag;
  logic signed [17:0] alt;
  logic signed [17:0] zref_next;
  logic               out_free;
  logic               out_load;
  logic               prod_hold;

  assign mag = prod[63:32];
  always_comb begin
    if (held_pressure == 24'd0) begin
      alt = bac_pkg::ALT_MAX;
    end else if (neg) begin
      alt = (mag > 32'd131072) ? bac_pkg::ALT_MIN : 18'(-$signed({1'b0, mag}));
    end else begin
      alt = (mag > 32'd131071) ? bac_pkg::ALT_MAX : $signed(mag[17:0]);
    end
    zref_next = (opcode == bac_pkg::OP_CAPTURE) ? alt : zero_reference;
  end

  assign out_free     = !out_valid || result.ready;
  assign out_load     = (state == S_DONE) && last_phase && out_free;
  // The final product must stay put while the result waits for the output.
  assign prod_hold    = (state == S_DONE) && last_phase && !out_free;
  assign sample.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (!prod_hold) begin
      prod <= mul_p;
    end
    if (rst) begin
      state            <= S_IDLE;
      held_pressure    <= 24'd0;
      held_temperature <= 16'sd0;
      zero_reference   <= 18'sd0;
      out_valid        <= 1'b0;
      step             <= 4'd0;
      last_phase       <= 1'b0;
    end else begin
      if (result.valid && result.ready && !out_load) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (sample.valid) begin
            opcode <= sample.opcode;
            if (sample.status_byte[1]) begin
              held_pressure <= sample.pressure_raw;
            end
            if (sample.status_byte[0]) begin
              held_temperature <= sample.temperature_raw;
            end
            state <= S_TMUL;
          end
        end
        S_TMUL:  state <= S_TCORR;
        S_TCORR: begin
          num   <= {kel, 8'd0};
          state <= S_FMUL;
        end
        S_FMUL:  state <= S_FCHK;
        S_FCHK: begin
          fq    <= prod[48:32];
          state <= S_FFIN;
        end
        S_FFIN: begin
          factor <= fq + (((num - prod[24:0]) >= 25'd273) ? 17'd1 : 17'd0);
          step   <= 4'd0;
          frac   <= 16'd0;
          state  <= S_LOG;
        end
        S_LOG: begin
          if (step != 4'd0) begin
            frac[4'd15 - (step - 4'd1)] <= sq_bit;
          end
          step <= step + 4'd1;
          if (step == 4'd15) begin
            state <= S_DLOG;
          end
        end
        S_DLOG: begin
          neg   <= d[23];
          mag_d <= d[23] ? 23'(-d) : d[22:0];
          state <= S_DMUL;
        end
        S_DMUL:  state <= S_LMUL;
        S_LMUL: begin
          last_phase <= 1'b0;
          state      <= S_DONE;
        end
        S_DONE: begin
          if (!last_phase) begin
            last_phase <= 1'b1;
          end else if (out_free) begin
            out_valid      <= 1'b1;
            out_abs        <= alt;
            out_rel        <= 19'(alt) - 19'(zref_next);
            zero_reference <= zref_next;
            last_phase     <= 1'b0;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign result.valid        = out_valid;
  assign result.altitude_abs = out_abs;
  assign result.altitude_rel = out_rel;

endmodule
